FILE: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes of the I2C bit-level master: command modes,
// configuration register indexes, request payloads and reset values.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // command modes
    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_RESTART = 3'd1;
    localparam logic [2:0] MODE_STOP    = 3'd2;
    localparam logic [2:0] MODE_WRITE   = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;
    localparam logic [2:0] MODE_POLL    = 3'd5;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIM    = 2'd2;
    localparam int CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [9:0]  HALF_PERIOD_RST = 10'd40;
    localparam logic [15:0] STRETCH_LIM_RST = 16'd5000;
    localparam logic [15:0] POLL_LIM_RST    = 16'd5000;

    // byte values
    localparam logic [7:0] BYTE_MSB     = 8'h80;
    localparam logic [7:0] BYTE_TIMEOUT = 8'hFF;

    // one input request: tick, command and bus samples
    typedef struct packed {
        logic       tick;
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] cmd_byte;
        logic       ack_to_send;
        logic       scl_sample;
        logic       sda_sample;
    } in_item_t;

    // one result request: line drives and command status
    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       nack_seen;
        logic       stretch_timeout;
    } out_item_t;

    // effective configuration handed to the bit engine
    typedef struct packed {
        logic [9:0]  half_period_ticks;
        logic [15:0] stretch_limit;
        logic [15:0] poll_retry_limit;
    } cfg_t;

endpackage

FILE: sv/i2cm_in_if.sv
// ----------------------------------------------------------------------------
// i2cm_in_if
// Valid/ready channel carrying one input request of the I2C master.
// ----------------------------------------------------------------------------
interface i2cm_in_if import i2cm_pkg::*; ();

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: sv/i2cm_out_if.sv
// ----------------------------------------------------------------------------
// i2cm_out_if
// Valid/ready channel carrying one result request of the I2C master.
// ----------------------------------------------------------------------------
interface i2cm_out_if import i2cm_pkg::*; ();

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: sv/i2cm_cfg_if.sv
// ----------------------------------------------------------------------------
// i2cm_cfg_if
// Register write channel: register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface i2cm_cfg_if import i2cm_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);

endinterface

FILE: sv/i2cm_regs.sv
// ----------------------------------------------------------------------------
// i2cm_regs
// Configuration registers of the I2C master. A zero value acts as one on
// the effective outputs.
// ----------------------------------------------------------------------------
module i2cm_regs import i2cm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    i2cm_cfg_if.sink       cfg,
    output cfg_t           cfg_eff
);

    logic [9:0]  half_period_reg;
    logic [15:0] stretch_lim_reg;
    logic [15:0] poll_lim_reg;

    assign cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RST;
            stretch_lim_reg <= STRETCH_LIM_RST;
            poll_lim_reg    <= POLL_LIM_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_HALF_PERIOD: half_period_reg <= cfg.wdata[9:0];
                CFG_STRETCH_LIM: stretch_lim_reg <= cfg.wdata;
                CFG_POLL_LIM:    poll_lim_reg    <= cfg.wdata;
                default:         ;
            endcase
        end
    end

    // zero reads as one
    always_comb
    begin
        cfg_eff.half_period_ticks = (half_period_reg == '0) ? 10'd1 : half_period_reg;
        cfg_eff.stretch_limit     = (stretch_lim_reg == '0) ? 16'd1 : stretch_lim_reg;
        cfg_eff.poll_retry_limit  = (poll_lim_reg == '0) ? 16'd1 : poll_lim_reg;
    end

endmodule

FILE: sv/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Bit engine of the I2C master: phase sequencer, shift register and the
// half-period, stretch and polling counters. State advances once per
// accepted request; the result of that step is presented combinationally.
// ----------------------------------------------------------------------------
module i2cm_core import i2cm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    input  cfg_t      cfg_eff,
    output out_item_t result
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_RS_A, PH_RS_B, PH_RS_C, PH_ST_A,
        PH_WB_LOW, PH_WB_HIGH, PH_WB_HOLD, PH_WA_LOW, PH_WA_HIGH, PH_WA_HOLD,
        PH_RB_LOW, PH_RB_HIGH, PH_RB_WAIT, PH_RA_LOW, PH_RA_HIGH, PH_RA_HOLD,
        PH_SP_A, PH_SP_B, PH_SP_C
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  active_mode;
        logic [7:0]  shift_byte;
        logic [3:0]  bit_count;
        logic [9:0]  hp_count;
        logic [15:0] stretch_count;
        logic [15:0] poll_count;
        logic        ack_choice;
        logic        scl_drv;
        logic        sda_drv;
        logic [7:0]  addr_hold;
        logic        pend_nack;
        logic        pend_to;
        logic [7:0]  res_data;
        logic        res_nack;
        logic        res_to;
        logic        done_now;
    } core_st_t;

    core_st_t st_reg;
    core_st_t st_next;

    // enter a phase and apply its line change
    function automatic core_st_t go_f(input core_st_t s_in, input phase_t ph);
        core_st_t s;
        s = s_in;
        s.phase         = ph;
        s.hp_count      = '0;
        s.stretch_count = '0;
        case (ph)
            PH_RS_A:   s.scl_drv = 1'b1;
            PH_RS_B:   s.sda_drv = 1'b0;
            PH_ST_A:
            begin
                s.sda_drv    = 1'b1;
                s.shift_byte = s.addr_hold;
                s.bit_count  = '0;
            end
            PH_WB_LOW:
            begin
                s.scl_drv = 1'b1;
                s.sda_drv = ((s.shift_byte & BYTE_MSB) == '0);
            end
            PH_RS_C, PH_WB_HIGH, PH_WA_HIGH, PH_RB_HIGH, PH_RA_HIGH, PH_SP_B:
                s.scl_drv = 1'b0;
            PH_WA_LOW, PH_RB_LOW:
            begin
                s.scl_drv = 1'b1;
                s.sda_drv = 1'b0;
            end
            PH_RA_LOW:
            begin
                s.scl_drv = 1'b1;
                s.sda_drv = s.ack_choice;
            end
            PH_SP_A:
            begin
                s.scl_drv = 1'b1;
                s.sda_drv = 1'b1;
            end
            PH_SP_C:   s.sda_drv = 1'b0;
            default:   ;
        endcase
        return s;
    endfunction

    // end of command: latch status
    function automatic core_st_t finish_f(input core_st_t s_in);
        core_st_t s;
        s = s_in;
        s.phase         = PH_IDLE;
        s.hp_count      = '0;
        s.stretch_count = '0;
        s.done_now      = 1'b1;
        s.res_to        = s.pend_to;
        s.res_nack      = s.pend_nack;
        if (s.pend_to)
            s.res_data = BYTE_TIMEOUT;
        else
            s.res_data = (s.active_mode == MODE_READ) ? s.shift_byte : 8'd0;
        return s;
    endfunction

    logic [9:0]  hp_inc;
    logic        hp_done;
    logic [15:0] st_inc;
    logic        st_over;
    logic [15:0] poll_inc;
    logic [3:0]  bit_inc;
    logic        scl_hi;

    // counter increments and compares
    always_comb
    begin
        hp_inc   = st_reg.hp_count + 10'd1;
        hp_done  = (hp_inc >= cfg_eff.half_period_ticks);
        st_inc   = st_reg.stretch_count + 16'd1;
        st_over  = (st_inc >= cfg_eff.stretch_limit);
        poll_inc = st_reg.poll_count + 16'd1;
        bit_inc  = st_reg.bit_count + 4'd1;
        scl_hi   = item.scl_sample;
    end

    // one step of the sequencer
    always_comb
    begin
        st_next          = st_reg;
        st_next.done_now = 1'b0;
        if (st_reg.phase == PH_IDLE)
        begin
            if (item.cmd_valid && (item.mode <= MODE_POLL))
            begin
                st_next.active_mode = item.mode;
                st_next.addr_hold   = item.cmd_byte;
                st_next.ack_choice  = item.ack_to_send;
                st_next.pend_nack   = 1'b0;
                st_next.pend_to     = 1'b0;
                st_next.poll_count  = '0;
                st_next.bit_count   = '0;
                case (item.mode)
                    MODE_START, MODE_POLL: st_next = go_f(st_next, PH_ST_A);
                    MODE_RESTART:          st_next = go_f(st_next, PH_RS_A);
                    MODE_STOP:             st_next = go_f(st_next, PH_SP_A);
                    MODE_WRITE:
                    begin
                        st_next.shift_byte = item.cmd_byte;
                        st_next = go_f(st_next, PH_WB_LOW);
                    end
                    default:
                    begin
                        st_next.shift_byte = '0;
                        st_next = go_f(st_next, PH_RB_LOW);
                    end
                endcase
            end
        end
        else if (item.tick)
        begin
            case (st_reg.phase)
                PH_RS_A, PH_RS_B, PH_RS_C, PH_ST_A, PH_WB_LOW, PH_WA_LOW,
                PH_RB_LOW, PH_RB_HIGH, PH_RA_LOW, PH_SP_A, PH_SP_B:
                begin
                    st_next.hp_count = hp_inc;
                    if (hp_done)
                    begin
                        case (st_reg.phase)
                            PH_RS_A:    st_next = go_f(st_next, PH_RS_B);
                            PH_RS_B:    st_next = go_f(st_next, PH_RS_C);
                            PH_RS_C:    st_next = go_f(st_next, PH_ST_A);
                            PH_ST_A:    st_next = go_f(st_next, PH_WB_LOW);
                            PH_WB_LOW:  st_next = go_f(st_next, PH_WB_HIGH);
                            PH_WA_LOW:  st_next = go_f(st_next, PH_WA_HIGH);
                            PH_RB_LOW:  st_next = go_f(st_next, PH_RB_HIGH);
                            PH_RB_HIGH: st_next = go_f(st_next, PH_RB_WAIT);
                            PH_RA_LOW:  st_next = go_f(st_next, PH_RA_HIGH);
                            PH_SP_A:    st_next = go_f(st_next, PH_SP_B);
                            default:    st_next = go_f(st_next, PH_SP_C);
                        endcase
                    end
                end
                PH_WB_HIGH, PH_WA_HIGH, PH_RB_WAIT, PH_RA_HIGH:
                begin
                    if (scl_hi)
                    begin
                        case (st_reg.phase)
                            PH_WB_HIGH: st_next = go_f(st_next, PH_WB_HOLD);
                            PH_WA_HIGH:
                            begin
                                st_next.pend_nack = item.sda_sample;
                                st_next = go_f(st_next, PH_WA_HOLD);
                            end
                            PH_RB_WAIT:
                            begin
                                st_next.shift_byte = {st_reg.shift_byte[6:0],
                                                      item.sda_sample};
                                st_next.bit_count  = bit_inc;
                                st_next = go_f(st_next, (bit_inc >= 4'd8) ?
                                               PH_RA_LOW : PH_RB_LOW);
                            end
                            default:    st_next = go_f(st_next, PH_RA_HOLD);
                        endcase
                    end
                    else
                    begin
                        // slave stretching the clock
                        st_next.stretch_count = st_inc;
                        if (st_over)
                        begin
                            st_next.pend_to   = 1'b1;
                            st_next.pend_nack = 1'b1;
                            st_next = go_f(st_next, PH_SP_A);
                        end
                    end
                end
                PH_WB_HOLD:
                begin
                    st_next.hp_count = hp_inc;
                    if (hp_done)
                    begin
                        st_next.shift_byte = {st_reg.shift_byte[6:0], 1'b0};
                        st_next.bit_count  = bit_inc;
                        st_next = go_f(st_next, (bit_inc >= 4'd8) ?
                                       PH_WA_LOW : PH_WB_LOW);
                    end
                end
                PH_WA_HOLD:
                begin
                    st_next.hp_count = hp_inc;
                    if (hp_done)
                    begin
                        st_next.scl_drv = 1'b1;
                        if ((st_reg.active_mode == MODE_POLL) && st_reg.pend_nack)
                            st_next = go_f(st_next, PH_SP_A);
                        else
                            st_next = finish_f(st_next);
                    end
                end
                PH_RA_HOLD:
                begin
                    st_next.hp_count = hp_inc;
                    if (hp_done)
                    begin
                        st_next.scl_drv = 1'b1;
                        st_next = finish_f(st_next);
                    end
                end
                PH_SP_C:
                begin
                    st_next.hp_count = hp_inc;
                    if (hp_done)
                    begin
                        // ack polling: retry start while NACKed
                        if (!st_reg.pend_to && (st_reg.active_mode == MODE_POLL) &&
                            st_reg.pend_nack)
                        begin
                            st_next.poll_count = poll_inc;
                            if (poll_inc >= cfg_eff.poll_retry_limit)
                                st_next = finish_f(st_next);
                            else
                            begin
                                st_next.pend_nack = 1'b0;
                                st_next = go_f(st_next, PH_ST_A);
                            end
                        end
                        else
                            st_next = finish_f(st_next);
                    end
                end
                default: st_next.phase = PH_IDLE;
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (advance)
            st_reg <= st_next;
    end

    // result of this step
    always_comb
    begin
        result.scl_pull_low    = st_next.scl_drv;
        result.sda_pull_low    = st_next.sda_drv;
        result.busy_res        = (st_next.phase != PH_IDLE);
        result.done_res        = st_next.done_now;
        result.read_data       = st_next.res_data;
        result.nack_seen       = st_next.res_nack;
        result.stretch_timeout = st_next.res_to;
    end

endmodule

FILE: sv/i2c_bit_level_master.sv
// A request's result is written into the output register by the edge that accepts it.
// Throughput: one request per cycle while the sink keeps up; the bit engine steps once per request.
// Ready falls only while a result waits in the output register and the sink is stalled.
// Reset: asynchronous, active low; bus released, sequencer idle, status
// cleared, registers at 40 ticks / 5000 ticks / 5000 poll retries. No clearing pass.
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// I2C master driving open-drain SCL and SDA, paced by tick requests: start,
// repeated start, stop, byte write, byte read and start with ack polling.
// ----------------------------------------------------------------------------
module i2c_bit_level_master import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2cm_in_if.sink     bus_item,
    i2cm_out_if.source  bus_result,
    i2cm_cfg_if.sink    cfg
);

    cfg_t      cfg_eff;
    out_item_t result;
    logic      accept;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;

    // configuration registers
    i2cm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_eff (cfg_eff)
    );

    // handshake: take a request whenever the output register frees up
    assign bus_item.ready = !out_valid_reg || bus_result.ready;
    assign accept         = bus_item.valid && bus_item.ready;

    // bit engine
    i2cm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .item    (bus_item.data),
        .cfg_eff (cfg_eff),
        .result  (result)
    );

    // output valid
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (bus_result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= result;
    end

    assign bus_result.valid = out_valid_reg;
    assign bus_result.data  = out_data_reg;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C bit-level master. A behavioral copy of the
// bit engine predicts the pin drives and command status for every accepted
// request. A simple bus model answers from the predicted line drives:
// clock stretching, stuck SCL, slave ACK/NACK and read bits. Directed tests
// cover each command, timeouts, ack polling and register extremes, followed
// by randomized transfers under two random register settings.
// ----------------------------------------------------------------------------
module tb import i2cm_pkg::*; ();

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    // bit engine phases
    typedef enum logic [4:0] {
        PH_IDLE, PH_RS_A, PH_RS_B, PH_RS_C, PH_ST_A,
        PH_WB_LOW, PH_WB_HIGH, PH_WB_HOLD, PH_WA_LOW, PH_WA_HIGH, PH_WA_HOLD,
        PH_RB_LOW, PH_RB_HIGH, PH_RB_WAIT, PH_RA_LOW, PH_RA_HIGH, PH_RA_HOLD,
        PH_SP_A, PH_SP_B, PH_SP_C
    } bus_phase_t;

    // how the modeled slave answers the ack slot of a written byte
    typedef enum logic [1:0] {SLAVE_RANDOM, SLAVE_ACK, SLAVE_NACK} slave_reply_t;

    logic clk;
    logic rst_n = 1'b0;

    i2cm_in_if  item_ch ();
    i2cm_out_if result_ch ();
    i2cm_cfg_if cfg_ch ();

    i2c_bit_level_master dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .bus_item   (item_ch),
        .bus_result (result_ch),
        .cfg        (cfg_ch)
    );

    // predicted engine state
    logic [9:0]  half_period_reg;
    logic [15:0] stretch_lim_reg;
    logic [15:0] poll_lim_reg;
    bus_phase_t  phase_q;
    logic [2:0]  act_mode;
    logic [7:0]  shifter;
    logic [3:0]  bits_done;
    logic [15:0] half_cnt;
    logic [15:0] stretch_cnt;
    logic [15:0] poll_cnt;
    logic        ack_sel;
    logic        scl_low;
    logic        sda_low;
    logic [7:0]  addr_keep;
    logic        nack_pend;
    logic        timeout_pend;
    logic [7:0]  last_data;
    logic        last_nack;
    logic        last_timeout;
    logic        done_pulse;

    out_item_t expected_pins_q[$];
    int        engine_steps;
    int        mismatch_count;
    int unsigned cycle_count;

    // bus model and traffic knobs
    slave_reply_t slave_reply;
    bit scl_stuck;
    bit scl_was_low;
    int stretch_left;
    int stretch_max;
    int tick_pct;
    bit chatter_on;
    int send_burst;
    bit send_quiet;
    int recv_burst;
    bit recv_quiet;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL i2c_bit_level_master");
            $finish;
        end
    end

    function automatic int draw_wait(inout int burst_left, inout bit quiet);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(20, 200);
            quiet = ($urandom_range(0, 2) == 0);
        end
        burst_left--;
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic void reset_engine();
        half_period_reg = HALF_PERIOD_RST;
        stretch_lim_reg = STRETCH_LIM_RST;
        poll_lim_reg = POLL_LIM_RST;
        phase_q = PH_IDLE;
        act_mode = '0;
        shifter = '0;
        bits_done = '0;
        half_cnt = '0;
        stretch_cnt = '0;
        poll_cnt = '0;
        ack_sel = 1'b0;
        scl_low = 1'b0;
        sda_low = 1'b0;
        addr_keep = '0;
        nack_pend = 1'b0;
        timeout_pend = 1'b0;
        last_data = '0;
        last_nack = 1'b0;
        last_timeout = 1'b0;
        done_pulse = 1'b0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_HALF_PERIOD: half_period_reg = value[9:0];
            CFG_STRETCH_LIM: stretch_lim_reg = value;
            CFG_POLL_LIM:    poll_lim_reg = value;
            default: ;
        endcase
    endfunction

    // phase entry: restart the counters and apply the line change
    function automatic void enter_phase(bus_phase_t next);
        phase_q = next;
        half_cnt = '0;
        stretch_cnt = '0;
        case (next)
            PH_RS_A: scl_low = 1'b1;
            PH_RS_B: sda_low = 1'b0;
            PH_ST_A:
            begin
                sda_low = 1'b1;
                shifter = addr_keep;
                bits_done = '0;
            end
            PH_WB_LOW:
            begin
                scl_low = 1'b1;
                sda_low = ((shifter & BYTE_MSB) == 8'h00);
            end
            PH_RS_C, PH_WB_HIGH, PH_WA_HIGH, PH_RB_HIGH, PH_RA_HIGH, PH_SP_B:
                scl_low = 1'b0;
            PH_WA_LOW, PH_RB_LOW:
            begin
                scl_low = 1'b1;
                sda_low = 1'b0;
            end
            PH_RA_LOW:
            begin
                scl_low = 1'b1;
                sda_low = ack_sel;
            end
            PH_SP_A:
            begin
                scl_low = 1'b1;
                sda_low = 1'b1;
            end
            PH_SP_C: sda_low = 1'b0;
            default: ;
        endcase
    endfunction

    function automatic void close_command();
        phase_q = PH_IDLE;
        half_cnt = '0;
        stretch_cnt = '0;
        done_pulse = 1'b1;
        last_timeout = timeout_pend;
        last_nack = nack_pend;
        if (timeout_pend)
            last_data = BYTE_TIMEOUT;
        else
            last_data = (act_mode == MODE_READ) ? shifter : 8'h00;
    endfunction

    function automatic bit half_done();
        logic [15:0] hp;
        hp = (half_period_reg == '0) ? 16'd1 : {6'd0, half_period_reg};
        half_cnt = half_cnt + 16'd1;
        return half_cnt >= hp;
    endfunction

    // scl released: true once the line reads high, else count toward timeout
    function automatic bit scl_high(logic scl);
        logic [15:0] lim;
        lim = (stretch_lim_reg == '0) ? 16'd1 : stretch_lim_reg;
        if (scl)
            return 1'b1;
        stretch_cnt = stretch_cnt + 16'd1;
        if (stretch_cnt >= lim)
        begin
            timeout_pend = 1'b1;
            nack_pend = 1'b1;
            enter_phase(PH_SP_A);
        end
        return 1'b0;
    endfunction

    // one engine step per accepted request
    function automatic out_item_t advance_bus(in_item_t it);
        logic [15:0] plim;
        out_item_t res;
        plim = (poll_lim_reg == '0) ? 16'd1 : poll_lim_reg;
        done_pulse = 1'b0;
        if (phase_q == PH_IDLE)
        begin
            if (it.cmd_valid && it.mode <= MODE_POLL)
            begin
                engine_steps++;
                act_mode = it.mode;
                addr_keep = it.cmd_byte;
                ack_sel = it.ack_to_send;
                nack_pend = 1'b0;
                timeout_pend = 1'b0;
                poll_cnt = '0;
                bits_done = '0;
                case (it.mode)
                    MODE_START, MODE_POLL: enter_phase(PH_ST_A);
                    MODE_RESTART: enter_phase(PH_RS_A);
                    MODE_STOP: enter_phase(PH_SP_A);
                    MODE_WRITE:
                    begin
                        shifter = it.cmd_byte;
                        enter_phase(PH_WB_LOW);
                    end
                    default:
                    begin
                        shifter = '0;
                        enter_phase(PH_RB_LOW);
                    end
                endcase
            end
        end
        else if (it.tick)
        begin
            engine_steps++;
            case (phase_q)
                PH_RS_A: if (half_done()) enter_phase(PH_RS_B);
                PH_RS_B: if (half_done()) enter_phase(PH_RS_C);
                PH_RS_C: if (half_done()) enter_phase(PH_ST_A);
                PH_ST_A: if (half_done()) enter_phase(PH_WB_LOW);
                PH_WB_LOW: if (half_done()) enter_phase(PH_WB_HIGH);
                PH_WB_HIGH: if (scl_high(it.scl_sample)) enter_phase(PH_WB_HOLD);
                PH_WB_HOLD:
                    if (half_done())
                    begin
                        shifter = shifter << 1;
                        bits_done = bits_done + 4'd1;
                        enter_phase((bits_done >= 4'd8) ? PH_WA_LOW : PH_WB_LOW);
                    end
                PH_WA_LOW: if (half_done()) enter_phase(PH_WA_HIGH);
                PH_WA_HIGH:
                    if (scl_high(it.scl_sample))
                    begin
                        nack_pend = it.sda_sample;
                        enter_phase(PH_WA_HOLD);
                    end
                PH_WA_HOLD:
                    if (half_done())
                    begin
                        scl_low = 1'b1;
                        if (act_mode == MODE_POLL && nack_pend)
                            enter_phase(PH_SP_A);
                        else
                            close_command();
                    end
                PH_RB_LOW: if (half_done()) enter_phase(PH_RB_HIGH);
                PH_RB_HIGH: if (half_done()) enter_phase(PH_RB_WAIT);
                PH_RB_WAIT:
                    if (scl_high(it.scl_sample))
                    begin
                        shifter = {shifter[6:0], it.sda_sample};
                        bits_done = bits_done + 4'd1;
                        enter_phase((bits_done >= 4'd8) ? PH_RA_LOW : PH_RB_LOW);
                    end
                PH_RA_LOW: if (half_done()) enter_phase(PH_RA_HIGH);
                PH_RA_HIGH: if (scl_high(it.scl_sample)) enter_phase(PH_RA_HOLD);
                PH_RA_HOLD:
                    if (half_done())
                    begin
                        scl_low = 1'b1;
                        close_command();
                    end
                PH_SP_A: if (half_done()) enter_phase(PH_SP_B);
                PH_SP_B: if (half_done()) enter_phase(PH_SP_C);
                PH_SP_C:
                    if (half_done())
                    begin
                        // a NACKed polling attempt retries until the limit
                        if (!timeout_pend && act_mode == MODE_POLL && nack_pend)
                        begin
                            poll_cnt = poll_cnt + 16'd1;
                            if (poll_cnt >= plim)
                                close_command();
                            else
                            begin
                                nack_pend = 1'b0;
                                enter_phase(PH_ST_A);
                            end
                        end
                        else
                            close_command();
                    end
                default: phase_q = PH_IDLE;
            endcase
        end
        res.scl_pull_low = scl_low;
        res.sda_pull_low = sda_low;
        res.busy_res = (phase_q != PH_IDLE);
        res.done_res = done_pulse;
        res.read_data = last_data;
        res.nack_seen = last_nack;
        res.stretch_timeout = last_timeout;
        return res;
    endfunction

    // next request: pin samples follow the predicted line drives
    function automatic in_item_t make_item(logic cv, logic [2:0] md, logic [7:0] bt, logic ack);
        in_item_t it;
        it.tick = ($urandom_range(1, 100) <= tick_pct);
        it.cmd_valid = cv;
        it.mode = md;
        it.cmd_byte = bt;
        it.ack_to_send = ack;
        // slave may stretch right after scl is released
        if (scl_was_low && !scl_low && $urandom_range(0, 3) == 0)
            stretch_left = $urandom_range(1, stretch_max);
        scl_was_low = scl_low;
        if (scl_low)
            it.scl_sample = ($urandom_range(0, 7) == 0);
        else if (scl_stuck || stretch_left != 0)
        begin
            it.scl_sample = 1'b0;
            if (it.tick && stretch_left != 0)
                stretch_left--;
        end
        else
            it.scl_sample = 1'b1;
        // sda: own drive, slave ack slot, or slave data
        if (sda_low)
            it.sda_sample = ($urandom_range(0, 15) == 0);
        else if (phase_q inside {PH_WA_LOW, PH_WA_HIGH, PH_WA_HOLD})
        begin
            case (slave_reply)
                SLAVE_ACK:  it.sda_sample = 1'b0;
                SLAVE_NACK: it.sda_sample = 1'b1;
                default:    it.sda_sample = ($urandom_range(0, 2) == 0);
            endcase
        end
        else
            it.sda_sample = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // present one request and record its expected result once taken
    task automatic send_item(input in_item_t it);
        int gap;
        gap = draw_wait(send_burst, send_quiet);
        @(negedge clk);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        do @(posedge clk); while (!item_ch.ready);
        expected_pins_q.push_back(advance_bus(it));
    endtask

    // keep ticking until the engine goes idle
    task automatic tick_until_idle();
        logic cv;
        while (phase_q != PH_IDLE)
        begin
            cv = chatter_on && ($urandom_range(0, 7) == 0);
            send_item(make_item(cv, 3'($urandom_range(0, 7)), 8'($urandom),
                1'($urandom_range(0, 1))));
        end
    endtask

    task automatic run_command(input logic [2:0] md, input logic [7:0] bt, input logic ack);
        tick_until_idle();
        send_item(make_item(1'b1, md, bt, ack));
        tick_until_idle();
    endtask

    // let the engine finish and every result drain
    task automatic settle();
        tick_until_idle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_pins_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        apply_reg(idx, value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    // result sink with random stalls
    initial
    begin
        out_item_t got;
        out_item_t want;
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(recv_burst, recv_quiet);
            @(negedge clk);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
            got = result_ch.data;
            if (expected_pins_q.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_pins_q.pop_front();
                check_field("scl_pull_low", 8'(want.scl_pull_low),
                    8'(got.scl_pull_low));
                check_field("sda_pull_low", 8'(want.sda_pull_low),
                    8'(got.sda_pull_low));
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                check_field("read_data", want.read_data, got.read_data);
                check_field("nack_seen", 8'(want.nack_seen), 8'(got.nack_seen));
                check_field("stretch_timeout", 8'(want.stretch_timeout),
                    8'(got.stretch_timeout));
            end
        end
    end

    // reset register values: a stop at the default half period
    task automatic test_reset_values();
        slave_reply = SLAVE_ACK;
        tick_pct = 100;
        run_command(MODE_STOP, 8'h00, 1'b0);
        settle();
    endtask

    // every command, unused modes, and commands while busy
    task automatic test_each_command();
        write_reg(CFG_HALF_PERIOD, 16'd1);
        write_reg(CFG_STRETCH_LIM, 16'd20);
        write_reg(CFG_POLL_LIM, 16'd4);
        tick_pct = 80;
        chatter_on = 1'b1;
        run_command(MODE_SPARE_A, 8'hFF, 1'b1);
        run_command(MODE_SPARE_B, 8'h00, 1'b0);
        run_command(MODE_START, 8'h00, 1'b0);
        run_command(MODE_WRITE, 8'hFF, 1'b1);
        slave_reply = SLAVE_NACK;
        run_command(MODE_WRITE, BYTE_MSB, 1'b0);
        slave_reply = SLAVE_RANDOM;
        run_command(MODE_RESTART, 8'h01, 1'b1);
        run_command(MODE_READ, 8'h00, 1'b1);
        run_command(MODE_READ, 8'hFF, 1'b0);
        run_command(MODE_STOP, 8'h55, 1'b1);
        settle();
    endtask

    // scl held low past the limit in a write, a read and a polling start
    task automatic test_stretch_timeout();
        write_reg(CFG_STRETCH_LIM, 16'd1);
        scl_stuck = 1'b1;
        run_command(MODE_WRITE, 8'h3C, 1'b0);
        write_reg(CFG_STRETCH_LIM, 16'd3);
        run_command(MODE_READ, 8'h00, 1'b1);
        slave_reply = SLAVE_NACK;
        run_command(MODE_POLL, 8'hA0, 1'b0);
        // stretches shorter than the limit
        scl_stuck = 1'b0;
        slave_reply = SLAVE_RANDOM;
        write_reg(CFG_STRETCH_LIM, 16'd6);
        stretch_max = 5;
        run_command(MODE_START, 8'h5A, 1'b0);
        run_command(MODE_READ, 8'h00, 1'b0);
        stretch_max = 3;
        settle();
    endtask

    // polling: exhausted at several limits, zero limit, success
    task automatic test_ack_polling();
        write_reg(CFG_STRETCH_LIM, 16'd100);
        slave_reply = SLAVE_NACK;
        write_reg(CFG_POLL_LIM, 16'd1);
        run_command(MODE_POLL, 8'hA1, 1'b0);
        write_reg(CFG_POLL_LIM, 16'd3);
        run_command(MODE_POLL, 8'hA2, 1'b1);
        write_reg(CFG_POLL_LIM, 16'd0);
        run_command(MODE_POLL, 8'hA3, 1'b0);
        slave_reply = SLAVE_ACK;
        write_reg(CFG_POLL_LIM, 16'd2);
        run_command(MODE_POLL, 8'hA4, 1'b0);
        slave_reply = SLAVE_RANDOM;
        write_reg(CFG_POLL_LIM, 16'd5);
        run_command(MODE_POLL, 8'hA5, 1'b1);
        settle();
    endtask

    // register extremes, zero values, wide data and the unused index
    task automatic test_register_extremes();
        tick_pct = 100;
        chatter_on = 1'b0;
        write_reg(CFG_HALF_PERIOD, 16'd0);
        run_command(MODE_STOP, 8'h00, 1'b0);
        write_reg(CFG_HALF_PERIOD, 16'd1023);
        write_reg(CFG_HALF_PERIOD, 16'hFC01);
        run_command(MODE_STOP, 8'h00, 1'b0);
        write_reg(CFG_SPARE, 16'hFFFF);
        run_command(MODE_STOP, 8'h00, 1'b0);
        scl_stuck = 1'b1;
        write_reg(CFG_STRETCH_LIM, 16'd0);
        run_command(MODE_WRITE, 8'hC3, 1'b0);
        scl_stuck = 1'b0;
        write_reg(CFG_STRETCH_LIM, 16'hFFFF);
        run_command(MODE_WRITE, 8'h81, 1'b0);
        slave_reply = SLAVE_ACK;
        write_reg(CFG_POLL_LIM, 16'hFFFF);
        run_command(MODE_POLL, 8'h7E, 1'b0);
        slave_reply = SLAVE_RANDOM;
        settle();
    endtask

    // one bus transfer with random content, sometimes broken up
    task automatic run_transfer();
        int n;
        if ($urandom_range(0, 3) == 0)
            run_command(MODE_POLL, 8'($urandom), 1'($urandom_range(0, 1)));
        else
            run_command(MODE_START, 8'($urandom), 1'($urandom_range(0, 1)));
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 1) == 0)
                run_command(MODE_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
            else
                run_command(MODE_READ, 8'($urandom), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            run_command(MODE_RESTART, 8'($urandom), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 2))
                run_command(MODE_READ, 8'($urandom), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 7) != 0)
            run_command(MODE_STOP, 8'($urandom), 1'($urandom_range(0, 1)));
        // stray command, any mode
        if ($urandom_range(0, 7) == 0)
            run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
        // idle requests with no command
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                send_item(make_item(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
                    1'($urandom_range(0, 1))));
    endtask

    task automatic test_random_traffic();
        int target;
        for (int round = 0; round < 2; round++)
        begin
            write_reg(CFG_HALF_PERIOD, 16'($urandom_range(1, 3)));
            write_reg(CFG_STRETCH_LIM, 16'($urandom_range(3, 12)));
            write_reg(CFG_POLL_LIM, 16'($urandom_range(1, 6)));
            slave_reply = SLAVE_RANDOM;
            tick_pct = 75;
            chatter_on = 1'b1;
            stretch_max = $urandom_range(2, 10);
            target = engine_steps + 20;
            while (engine_steps < target)
                run_transfer();
        end
        settle();
    endtask

    // test sequence
    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        engine_steps = 0;
        slave_reply = SLAVE_RANDOM;
        scl_stuck = 1'b0;
        scl_was_low = 1'b0;
        stretch_left = 0;
        stretch_max = 3;
        tick_pct = 100;
        chatter_on = 1'b0;
        send_burst = 0;
        send_quiet = 1'b0;
        recv_burst = 0;
        recv_quiet = 1'b0;
        reset_engine();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_each_command();
        test_stretch_timeout();
        test_ack_polling();
        test_register_extremes();
        test_random_traffic();

        if (mismatch_count == 0)
            $display("PASS i2c_bit_level_master");
        else
            $display("FAIL i2c_bit_level_master");
        $finish;
    end

endmodule

FILE: filelist.f
sv/i2cm_pkg.sv
sv/i2cm_in_if.sv
sv/i2cm_out_if.sv
sv/i2cm_cfg_if.sv
sv/i2cm_regs.sv
sv/i2cm_core.sv
sv/i2c_bit_level_master.sv
test/tb.sv
